// ===== src/uer_pkg.sv =====
`default_nettype none

package uer_pkg;

    // Stream widths
    localparam int IN_W  = 8;
    localparam int OUT_W = 48;
    localparam int D_W   = 18;
    localparam int CFG_W = 18;
    localparam int IDX_W = 3;

    // Distance arithmetic
    localparam logic [D_W-1:0] D18_MAX    = 18'h3FFFF;
    localparam logic [18:0]    DIST_SCALE = 19'd287733;
    localparam logic [8:0]     ALPHA_ONE  = 9'd256;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_TRIGGER  = 3'd1;
    localparam logic [IDX_W-1:0] REG_TIMEOUT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_DIST = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_DIST = 3'd4;
    localparam logic [IDX_W-1:0] REG_ALPHA    = 3'd5;
    localparam logic [IDX_W-1:0] REG_OBSTACLE = 3'd6;

    // Measurement status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Measurement phase of the ranger
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_HIGH = 2'd3
    } phase_t;

    // Controller sequence
    typedef enum logic [2:0] {
        C_IDLE  = 3'd0,
        C_CONV  = 3'd1,
        C_RANGE = 3'd2,
        C_FILT  = 3'd3,
        C_SUM   = 3'd4,
        C_WRITE = 3'd5
    } ctl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic step;
        logic conv;
        logic range_chk;
        logic filt;
        logic sum;
        logic load_out;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fin;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/uer_ctrl.sv =====
`default_nettype none

module uer_ctrl
    import uer_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t sts,
    output cmd_t       cmd
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.fin ? C_CONV : C_WRITE;
                end
            end
            C_CONV:  state_next = C_RANGE;
            C_RANGE: state_next = C_FILT;
            C_FILT:  state_next = C_SUM;
            C_SUM:   state_next = C_WRITE;
            C_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    // Outputs: commands and handshake
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            C_IDLE:
            begin
                in_ready = 1'b1;
                cmd.step = in_valid;
            end
            C_CONV:  cmd.conv      = 1'b1;
            C_RANGE: cmd.range_chk = 1'b1;
            C_FILT:  cmd.filt      = 1'b1;
            C_SUM:   cmd.sum       = 1'b1;
            C_WRITE: cmd.load_out  = !out_valid_reg || out_ready;
            default: cmd           = '0;
        endcase
    end

    // Output register valid: set on load, drop when taken
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/uer_dp.sv =====
`default_nettype none

module uer_dp
    import uer_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic [IN_W-1:0]  in_data,
    input  wire cmd_t             cmd,
    output stat_t                 sts,
    output logic [OUT_W-1:0]      out_data
);

    localparam int TB = TIMER_BITS;
    localparam int CW = (TB + 1 > 17) ? TB + 1 : 17;
    localparam int PW = TB + 19;
    localparam int MW = 27;
    localparam logic [TB-1:0] TIMER_MAX = '1;

    // Configuration registers
    logic           enable_reg;
    logic [7:0]     trig_ticks_reg;
    logic [15:0]    timeout_reg;
    logic [D_W-1:0] min_dist_reg;
    logic [D_W-1:0] max_dist_reg;
    logic [8:0]     alpha_reg;
    logic [D_W-1:0] obstacle_reg;

    // Ranger state
    phase_t         phase_reg, phase_next;
    logic [TB-1:0]  elapsed_reg, elapsed_next;
    logic [7:0]     pulse_reg, pulse_next;
    logic [TB-1:0]  width_reg, width_next;
    logic [D_W-1:0] raw_reg;
    logic [D_W-1:0] filt_reg;

    // Per-tick result and arithmetic pipeline
    logic             trig_reg, trig_next;
    logic             done_reg, done_next;
    logic [1:0]       status_reg, status_next;
    logic             ok_reg;
    logic [PW-1:0]    prod_reg;
    logic [MW-1:0]    mul_old_reg;
    logic [MW-1:0]    mul_new_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic           start;
    logic           echo;
    logic           fin;
    logic [7:0]     trig_len;
    logic [7:0]     pulse_inc;
    logic [TB:0]    elapsed_inc;
    logic           timeout_hit;
    logic [PW-1:0]  dist_shift;
    logic [D_W-1:0] dist_sat;
    logic           range_ok;
    logic [8:0]     alpha_eff;
    logic [8:0]     alpha_rest;
    logic [MW:0]    filt_sum;

    assign start = in_data[0];
    assign echo  = in_data[1];

    // Tick step: advance the measurement phase
    always_comb
    begin
        trig_len    = (trig_ticks_reg == 8'd0) ? 8'd1 : trig_ticks_reg;
        pulse_inc   = (pulse_reg < 8'd255) ? pulse_reg + 8'd1 : pulse_reg;
        elapsed_inc = {1'b0, elapsed_reg} + {{TB{1'b0}}, 1'b1};
        timeout_hit = (CW'(elapsed_inc) > CW'(timeout_reg)) || elapsed_inc[TB];

        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        pulse_next   = pulse_reg;
        width_next   = width_reg;
        trig_next    = 1'b0;
        done_next    = 1'b0;
        status_next  = ST_OK;
        fin          = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start && enable_reg)
                begin
                    trig_next  = 1'b1;
                    pulse_next = 8'd1;
                    if (8'd1 >= trig_len)
                    begin
                        phase_next   = PH_WAIT;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_TRIG;
                    end
                end
            end
            PH_TRIG:
            begin
                trig_next  = 1'b1;
                pulse_next = pulse_inc;
                if (pulse_inc >= trig_len)
                begin
                    phase_next   = PH_WAIT;
                    elapsed_next = '0;
                end
            end
            PH_WAIT:
            begin
                if (echo)
                begin
                    if (elapsed_reg < TIMER_MAX)
                    begin
                        elapsed_next = elapsed_inc[TB-1:0];
                    end
                    width_next = {{(TB-1){1'b0}}, 1'b1};
                    phase_next = PH_HIGH;
                end
                else if (timeout_hit)
                begin
                    done_next   = 1'b1;
                    status_next = ST_TIMEOUT;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    elapsed_next = elapsed_inc[TB-1:0];
                end
            end
            PH_HIGH:
            begin
                if (!echo)
                begin
                    fin        = 1'b1;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (timeout_hit)
                begin
                    done_next   = 1'b1;
                    status_next = ST_TIMEOUT;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    elapsed_next = elapsed_inc[TB-1:0];
                    if (width_reg < TIMER_MAX)
                    begin
                        width_next = width_reg + {{(TB-1){1'b0}}, 1'b1};
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    assign sts.fin = fin;

    // Distance: saturate the scaled width and check the accepted window
    always_comb
    begin
        dist_shift = prod_reg >> 16;
        dist_sat   = (dist_shift > PW'(D18_MAX)) ? D18_MAX : dist_shift[D_W-1:0];
        range_ok   = (dist_sat != '0) && (dist_sat >= min_dist_reg)
                     && (dist_sat <= max_dist_reg);
    end

    // Filter weights, old value weight clamped to one
    assign alpha_eff  = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_rest = ALPHA_ONE - alpha_eff;
    assign filt_sum   = {1'b0, mul_old_reg} + {1'b0, mul_new_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            trig_ticks_reg <= 8'd10;
            timeout_reg    <= 16'd30000;
            min_dist_reg   <= 18'd512;
            max_dist_reg   <= 18'd76800;
            alpha_reg      <= 9'd179;
            obstacle_reg   <= 18'd5120;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:   enable_reg     <= cfg_wdata[0];
                REG_TRIGGER:  trig_ticks_reg <= cfg_wdata[7:0];
                REG_TIMEOUT:  timeout_reg    <= cfg_wdata[15:0];
                REG_MIN_DIST: min_dist_reg   <= cfg_wdata[D_W-1:0];
                REG_MAX_DIST: max_dist_reg   <= cfg_wdata[D_W-1:0];
                REG_ALPHA:    alpha_reg      <= cfg_wdata[8:0];
                REG_OBSTACLE: obstacle_reg   <= cfg_wdata[D_W-1:0];
                default:      enable_reg     <= enable_reg;
            endcase
        end
    end

    // Ranger state: step on each request, store distance and filter on an in-range finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            pulse_reg   <= '0;
            width_reg   <= '0;
            raw_reg     <= '0;
            filt_reg    <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                pulse_reg   <= pulse_next;
                width_reg   <= width_next;
            end
            if (cmd.range_chk && range_ok)
            begin
                raw_reg <= dist_sat;
            end
            if (cmd.sum && ok_reg)
            begin
                filt_reg <= filt_sum[D_W+7:8];
            end
        end
    end

    // Result fields and arithmetic stages
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            trig_reg   <= trig_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
        if (cmd.conv)
        begin
            prod_reg <= PW'(width_reg) * PW'(DIST_SCALE);
        end
        if (cmd.range_chk)
        begin
            ok_reg     <= range_ok;
            status_reg <= range_ok ? ST_OK : ST_RANGE;
        end
        if (cmd.filt)
        begin
            mul_old_reg <= MW'(alpha_eff) * MW'(filt_reg);
            mul_new_reg <= MW'(alpha_rest) * MW'(raw_reg);
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{(OUT_W-42){1'b0}},
                             raw_reg < obstacle_reg,
                             filt_reg,
                             raw_reg,
                             status_reg,
                             done_reg,
                             phase_reg != PH_IDLE,
                             trig_reg};
        end
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

// ===== src/ultrasonic_echo_ranger_top.sv =====
// Ultrasonic echo ranger with exponential smoothing.
// Input stream: one request per microsecond tick, carrying start_req and the
// sampled echo level. Output stream: exactly one result per request, carrying
// the trigger level, busy and done flags, status, raw and filtered distance
// in Q.8 centimetres, and the obstacle flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 enable,
// 1 trigger_ticks, 2 timeout_ticks, 3 min, 4 max, 5 alpha, 6 obstacle);
// write only while no request is in flight.
// Sequence: an ordinary tick goes from acceptance straight to the output
// load; a tick that ends an echo runs through the distance multiply, the
// range check, the two filter multiplies, the filter sum and the output
// load. The output load waits while the output register is still full.
// The controller sequence takes one request at a time and accepts the next
// only after the previous result is loaded into the output register.
// The output register parts the two sides: a new request is accepted while
// the previous result still waits; if the receiver stalls, the next result
// is held in the datapath until the output register frees.
// Reset (rst_n, asynchronous) restores the register defaults, idles the
// ranger, clears the stored distances and empties the output register.
`default_nettype none

module ultrasonic_echo_ranger_top
    import uer_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Input stream
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,  // [0] start_req, [1] echo
    // Output stream
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,  // [0] trigger, [1] busy_res,
                                                  // [2] done_res, [4:3] status,
                                                  // [22:5] distance_q8,
                                                  // [40:23] filtered_q8,
                                                  // [41] obstacle
    // Configuration
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    cmd_t  cmd;
    stat_t sts;

    uer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    uer_dp #(
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== src/uer_checker.sv =====
`default_nettype none

module uer_checker
    import uer_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // One request at a time: drop ready after an acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous still in work");

    // A finished measurement leaves the ranger idle with the trigger low
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1] && !m_axis_tdata[0])
        else $error("done reported while busy or triggering");

    // Status stays ok unless a measurement finished
    a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[4:3] == ST_OK)
        else $error("status set without done");

    // Trigger only while a measurement is running
    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("trigger high while idle");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
